[rtl/core/prdg_pkg.sv]
// ----------------------------------------------------------------------------
// prdg_pkg
// Shared types, widths and helpers for the pinhole ray direction generator.
// ----------------------------------------------------------------------------
package prdg_pkg;

    localparam int MUL_W = 35;   // shared multiplier operand width, signed
    localparam int ACC_W = 64;
    localparam int MAG_W = 56;   // raw component magnitudes stay below 2^50
    localparam int BX_W  = 21;   // subsample offset in half-subpixel units

    localparam logic [2:0] CFG_PIXEL_SIZE    = 3'd0;
    localparam logic [2:0] CFG_VIEW_DISTANCE = 3'd1;
    localparam logic [2:0] CFG_BASIS_U       = 3'd2;
    localparam logic [2:0] CFG_BASIS_V       = 3'd3;
    localparam logic [2:0] CFG_BASIS_W       = 3'd4;
    localparam logic [2:0] CFG_GRID_N        = 3'd5;
    localparam logic [2:0] CFG_HORIZ_RES     = 3'd6;
    localparam logic [2:0] CFG_VERT_RES      = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WS,
        S_TU,
        S_TV,
        S_SUM,
        S_PS,
        S_W,
        S_D,
        S_MAG,
        S_NORM,
        S_SQ,
        S_SQA,
        S_ROOT,
        S_DIVI,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic               ge;
        logic [ACC_W-1:0]   diff;
    } cs_res_t;

    // component 0 is x (top 16 bits), 2 is z (bottom)
    function automatic logic signed [15:0] basis_comp(input logic [47:0] pk,
                                                      input logic [1:0]  idx);
        logic signed [15:0] c;
        case (idx)
            2'd0:    c = pk[47:32];
            2'd1:    c = pk[31:16];
            default: c = pk[15:0];
        endcase
        return c;
    endfunction

endpackage

[rtl/core/prdg_mul.sv]
// ----------------------------------------------------------------------------
// prdg_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module prdg_mul (
    input  logic                                  aclk,
    input  logic signed [prdg_pkg::MUL_W-1:0]     op_a,
    input  logic signed [prdg_pkg::MUL_W-1:0]     op_b,
    output logic signed [2*prdg_pkg::MUL_W-1:0]   prod
);

    logic signed [2*prdg_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[rtl/core/prdg_cmpsub.sv]
// ----------------------------------------------------------------------------
// prdg_cmpsub
// Compare-and-subtract step shared by the square root and the divider.
// ----------------------------------------------------------------------------
module prdg_cmpsub (
    input  logic [prdg_pkg::ACC_W-1:0] op_a,
    input  logic [prdg_pkg::ACC_W-1:0] op_b,
    output prdg_pkg::cs_res_t          res
);

    always_comb begin
        res.ge   = (op_a >= op_b);
        res.diff = op_a - op_b;
    end

endmodule

[rtl/core/pinhole_ray_direction_generator_top.sv]
// ----------------------------------------------------------------------------
// pinhole_ray_direction_generator_top
// Pinhole camera primary ray directions with regular n x n supersampling.
// ----------------------------------------------------------------------------
// Each accepted pixel beat yields n squared ray beats (n is grid_n, with 0
// taken as 1 and capped at MAX_GRID), row-major over the subsamples, m_tlast
// on the final one. Every subsample runs through one shared 35x35 multiplier
// and one 64-bit compare-subtract unit under a small sequencer: the raw
// vector, normalising shifts (one bit a cycle), the squares, the square root
// (one result bit a cycle) and three 16-step divisions, in that order. The
// input is not ready while a pixel is in work; a finished ray waits in the
// output register, so the next pixel is taken while the last ray is held.
// ----------------------------------------------------------------------------
module pinhole_ray_direction_generator_top #(
    parameter int MAX_GRID = 8,
    parameter int MAX_RES  = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: pixel_row[11:0], pixel_col[23:12]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // tdata: dir_x[15:0], dir_y[31:16], dir_z[47:32], sub_row[50:48],
    //        sub_col[53:51], zero pad[55:54]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int MUL_W = prdg_pkg::MUL_W;
    localparam int ACC_W = prdg_pkg::ACC_W;
    localparam int MAG_W = prdg_pkg::MAG_W;
    localparam int BX_W  = prdg_pkg::BX_W;

    // configuration
    logic [15:0] pixel_size_reg, view_distance_reg;
    logic [47:0] basis_u_reg, basis_v_reg, basis_w_reg;
    logic [3:0]  grid_n_reg;
    logic [12:0] horiz_res_reg, vert_res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_size_reg    <= 16'd256;
            view_distance_reg <= 16'd500;
            basis_u_reg       <= 48'h4000_0000_0000;
            basis_v_reg       <= 48'h0000_4000_0000;
            basis_w_reg       <= 48'h0000_0000_4000;
            grid_n_reg        <= 4'd1;
            horiz_res_reg     <= 13'd640;
            vert_res_reg      <= 13'd480;
        end else if (cfg_valid) begin
            case (cfg_index)
                prdg_pkg::CFG_PIXEL_SIZE:    pixel_size_reg    <= cfg_data[15:0];
                prdg_pkg::CFG_VIEW_DISTANCE: view_distance_reg <= cfg_data[15:0];
                prdg_pkg::CFG_BASIS_U:       basis_u_reg       <= cfg_data;
                prdg_pkg::CFG_BASIS_V:       basis_v_reg       <= cfg_data;
                prdg_pkg::CFG_BASIS_W:       basis_w_reg       <= cfg_data;
                prdg_pkg::CFG_GRID_N:        grid_n_reg        <= cfg_data[3:0];
                prdg_pkg::CFG_HORIZ_RES:     horiz_res_reg     <= cfg_data[12:0];
                prdg_pkg::CFG_VERT_RES:      vert_res_reg      <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective grid and resolution
    logic [3:0]  n_eff;
    logic [13:0] hr_eff, vr_eff;
    logic [BX_W-1:0] t1x, t2x, t1y, t2y;

    always_comb begin
        if (grid_n_reg == 4'd0)
            n_eff = 4'd1;
        else if (grid_n_reg > 4'(MAX_GRID))
            n_eff = 4'(MAX_GRID);
        else
            n_eff = grid_n_reg;
        hr_eff = ({1'b0, horiz_res_reg} > 14'(MAX_RES)) ? 14'(MAX_RES)
                                                         : {1'b0, horiz_res_reg};
        vr_eff = ({1'b0, vert_res_reg} > 14'(MAX_RES)) ? 14'(MAX_RES)
                                                        : {1'b0, vert_res_reg};
        t1x = BX_W'({n_eff, 1'b0}) * BX_W'(s_tdata[23:12]);
        t2x = BX_W'(n_eff) * BX_W'(hr_eff);
        t1y = BX_W'({n_eff, 1'b0}) * BX_W'(s_tdata[11:0]);
        t2y = BX_W'(n_eff) * BX_W'(vr_eff);
    end

    // sequencer state and datapath registers
    prdg_pkg::state_t state_reg, state_next;

    logic [3:0]                n_reg;
    logic signed [BX_W-1:0]    basex_reg, basey_reg;
    logic [2:0]                p_reg, q_reg;
    logic [1:0]                i_reg;
    logic [4:0]                k_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [28:0]               wsc_reg;
    logic signed [ACC_W-1:0]   d_reg [3];
    logic [MAG_W-1:0]          m_reg [3];
    logic [2:0]                neg_reg;
    logic [MAG_W-1:0]          mx_reg;
    logic                      zero_reg;
    logic [ACC_W-1:0]          s_reg, r_reg, num_reg;
    logic [15:0]               qd_reg;
    logic [15:0]               dir_reg [3];

    logic                      m_valid_reg;
    logic [55:0]               m_data_reg;
    logic                      m_last_reg;

    logic signed [BX_W-1:0]    tx, ty;
    logic                      last_q, last_p, out_free;
    logic [ACC_W-1:0]          root_bit;

    assign tx       = basex_reg + BX_W'({q_reg, 1'b1});
    assign ty       = basey_reg + BX_W'({p_reg, 1'b1});
    assign last_q   = ({1'b0, q_reg} == n_reg - 4'd1);
    assign last_p   = ({1'b0, p_reg} == n_reg - 4'd1);
    assign out_free = !m_valid_reg || m_tready;
    assign root_bit = ACC_W'(1) << {k_reg, 1'b0};

    // shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic [ACC_W-1:0]          cs_a, cs_b;
    prdg_pkg::cs_res_t         cs_res;

    prdg_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    prdg_cmpsub u_cmpsub (
        .op_a (cs_a),
        .op_b (cs_b),
        .res  (cs_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prdg_pkg::S_IDLE: if (s_tvalid) state_next = prdg_pkg::S_WS;
            prdg_pkg::S_WS:   state_next = prdg_pkg::S_TU;
            prdg_pkg::S_TU:   state_next = prdg_pkg::S_TV;
            prdg_pkg::S_TV:   state_next = prdg_pkg::S_SUM;
            prdg_pkg::S_SUM:  state_next = prdg_pkg::S_PS;
            prdg_pkg::S_PS:   state_next = prdg_pkg::S_W;
            prdg_pkg::S_W:    state_next = prdg_pkg::S_D;
            prdg_pkg::S_D:    state_next = (i_reg == 2'd2) ? prdg_pkg::S_MAG
                                                           : prdg_pkg::S_TU;
            prdg_pkg::S_MAG:  state_next = prdg_pkg::S_NORM;
            prdg_pkg::S_NORM: begin
                if (mx_reg == '0)
                    state_next = prdg_pkg::S_EMIT;
                else if (mx_reg >= (MAG_W'(1) << 30) || mx_reg < (MAG_W'(1) << 29))
                    state_next = prdg_pkg::S_NORM;
                else
                    state_next = prdg_pkg::S_SQ;
            end
            prdg_pkg::S_SQ:   state_next = prdg_pkg::S_SQA;
            prdg_pkg::S_SQA:  state_next = (i_reg == 2'd2) ? prdg_pkg::S_ROOT
                                                           : prdg_pkg::S_SQ;
            prdg_pkg::S_ROOT: if (k_reg == 5'd0) state_next = prdg_pkg::S_DIVI;
            prdg_pkg::S_DIVI: state_next = prdg_pkg::S_DIV;
            prdg_pkg::S_DIV: begin
                if (k_reg == 5'd0)
                    state_next = (i_reg == 2'd2) ? prdg_pkg::S_EMIT : prdg_pkg::S_DIVI;
            end
            prdg_pkg::S_EMIT: begin
                if (out_free)
                    state_next = (last_p && last_q) ? prdg_pkg::S_IDLE : prdg_pkg::S_WS;
            end
            default: state_next = prdg_pkg::S_IDLE;
        endcase
    end

    // unit operand selection and handshake outputs
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        cs_a     = num_reg;
        cs_b     = r_reg << k_reg[3:0];
        s_tready = (state_reg == prdg_pkg::S_IDLE);
        case (state_reg)
            prdg_pkg::S_WS: begin
                mul_a = MUL_W'(view_distance_reg);
                mul_b = MUL_W'(n_reg);
            end
            prdg_pkg::S_TU: begin
                mul_a = MUL_W'(tx);
                mul_b = MUL_W'(prdg_pkg::basis_comp(basis_u_reg, i_reg));
            end
            prdg_pkg::S_TV: begin
                mul_a = MUL_W'(ty);
                mul_b = MUL_W'(prdg_pkg::basis_comp(basis_v_reg, i_reg));
            end
            prdg_pkg::S_PS: begin
                mul_a = acc_reg[MUL_W-1:0];
                mul_b = MUL_W'(pixel_size_reg);
            end
            prdg_pkg::S_W: begin
                mul_a = MUL_W'(wsc_reg);
                mul_b = MUL_W'(prdg_pkg::basis_comp(basis_w_reg, i_reg));
            end
            prdg_pkg::S_SQ: begin
                mul_a = MUL_W'(m_reg[i_reg][29:0]);
                mul_b = MUL_W'(m_reg[i_reg][29:0]);
            end
            prdg_pkg::S_ROOT: begin
                cs_a = s_reg;
                cs_b = r_reg + root_bit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= prdg_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            p_reg       <= '0;
            q_reg       <= '0;
            i_reg       <= '0;
            k_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == prdg_pkg::S_EMIT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                prdg_pkg::S_IDLE: begin
                    if (s_tvalid) begin
                        n_reg     <= n_eff;
                        basex_reg <= t1x - t2x;
                        basey_reg <= t1y - t2y;
                        p_reg     <= '0;
                        q_reg     <= '0;
                    end
                end
                prdg_pkg::S_WS:  i_reg <= '0;
                prdg_pkg::S_TU: begin
                    if (i_reg == 2'd0)
                        wsc_reg <= {prod[19:0], 9'd0};
                end
                prdg_pkg::S_TV:  acc_reg <= prod[ACC_W-1:0];
                prdg_pkg::S_SUM: acc_reg <= acc_reg + prod[ACC_W-1:0];
                prdg_pkg::S_W:   acc_reg <= prod[ACC_W-1:0];
                prdg_pkg::S_D: begin
                    d_reg[i_reg] <= acc_reg - prod[ACC_W-1:0];
                    i_reg        <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                end
                prdg_pkg::S_MAG: begin
                    logic [MAG_W-1:0] mg [3];
                    for (int j = 0; j < 3; j++) begin
                        mg[j] = d_reg[j][ACC_W-1] ? MAG_W'(-d_reg[j]) : MAG_W'(d_reg[j]);
                        m_reg[j]   <= mg[j];
                        neg_reg[j] <= d_reg[j][ACC_W-1];
                    end
                    mx_reg   <= (mg[0] > mg[1]) ? ((mg[0] > mg[2]) ? mg[0] : mg[2])
                                                : ((mg[1] > mg[2]) ? mg[1] : mg[2]);
                    zero_reg <= 1'b0;
                end
                prdg_pkg::S_NORM: begin
                    if (mx_reg == '0) begin
                        zero_reg <= 1'b1;
                    end else if (mx_reg >= (MAG_W'(1) << 30)) begin
                        mx_reg <= mx_reg >> 1;
                        for (int j = 0; j < 3; j++) m_reg[j] <= m_reg[j] >> 1;
                    end else if (mx_reg < (MAG_W'(1) << 29)) begin
                        mx_reg <= mx_reg << 1;
                        for (int j = 0; j < 3; j++) m_reg[j] <= m_reg[j] << 1;
                    end else begin
                        s_reg <= '0;
                        i_reg <= '0;
                    end
                end
                prdg_pkg::S_SQA: begin
                    s_reg <= s_reg + prod[ACC_W-1:0];
                    if (i_reg == 2'd2) begin
                        i_reg <= '0;
                        r_reg <= '0;
                        k_reg <= 5'd31;
                    end else begin
                        i_reg <= i_reg + 2'd1;
                    end
                end
                prdg_pkg::S_ROOT: begin
                    // one result bit of the integer square root a cycle
                    if (cs_res.ge) begin
                        s_reg <= cs_res.diff;
                        r_reg <= (r_reg >> 1) + root_bit;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    k_reg <= k_reg - 5'd1;
                end
                prdg_pkg::S_DIVI: begin
                    // rounded quotient: add half the divisor before dividing
                    num_reg <= (ACC_W'(m_reg[i_reg]) << 14) + (r_reg >> 1);
                    qd_reg  <= '0;
                    k_reg   <= 5'd15;
                end
                prdg_pkg::S_DIV: begin
                    logic [15:0] qn;
                    qn = qd_reg;
                    if (cs_res.ge) begin
                        num_reg          <= cs_res.diff;
                        qn[k_reg[3:0]]   = 1'b1;
                    end
                    qd_reg <= qn;
                    k_reg  <= k_reg - 5'd1;
                    if (k_reg == 5'd0) begin
                        dir_reg[i_reg] <= neg_reg[i_reg] ? -qn : qn;
                        i_reg          <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                    end
                end
                prdg_pkg::S_EMIT: begin
                    if (out_free) begin
                        m_last_reg  <= last_p && last_q;
                        if (zero_reg)
                            m_data_reg <= {2'b00, q_reg, p_reg, 48'd0};
                        else
                            m_data_reg <= {2'b00, q_reg, p_reg,
                                           dir_reg[2], dir_reg[1], dir_reg[0]};
                        if (last_q) begin
                            q_reg <= '0;
                            p_reg <= p_reg + 3'd1;
                        end else begin
                            q_reg <= q_reg + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[rtl/core/prdg_checker.sv]
// ----------------------------------------------------------------------------
// prdg_checker
// Port-level checks on the ray direction generator, bound to the top level.
// ----------------------------------------------------------------------------
module prdg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // a stalled ray beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("ray beat changed while stalled");

    // a pixel keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a pixel beat");

    // while a non-final ray waits, the pixel is still in work
    a_no_pixel_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before the last ray of a pixel");

    // unit vector components stay within one in Q2.14
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0])  <= 16'sd16384) &&
                     ($signed(m_tdata[15:0])  >= -16'sd16384) &&
                     ($signed(m_tdata[31:16]) <= 16'sd16384) &&
                     ($signed(m_tdata[31:16]) >= -16'sd16384) &&
                     ($signed(m_tdata[47:32]) <= 16'sd16384) &&
                     ($signed(m_tdata[47:32]) >= -16'sd16384))
        else $error("direction component out of range");

endmodule

bind pinhole_ray_direction_generator_top prdg_checker u_prdg_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Ray direction checks for the pinhole ray direction generator: pixel beats
// go in under random idling, every ray beat is compared with a predicted
// unit vector, subsample indices and last flag, over several camera settings.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [15:0] dx, dy, dz;
        logic [2:0]  prow, pcol;
        logic        last;
    } ray_t;

    int ray_cnt = 0;

    class ray_board;
        logic [15:0] psz, vdist;
        logic [47:0] bu, bv, bw;
        logic [3:0]  grid;
        logic [12:0] hres, vres;
        ray_t        pending[$];
        int          err_cnt = 0;
        int          seen = 0;

        task report(input string what, input longint got, input longint want);
            err_cnt++;
            $display("MISMATCH ray %0d %s: got %0h want %0h", seen, what, got, want);
        endtask

        function void set_reg(logic [2:0] idx, logic [47:0] val);
            case (idx)
                prdg_pkg::CFG_PIXEL_SIZE:    psz   = val[15:0];
                prdg_pkg::CFG_VIEW_DISTANCE: vdist = val[15:0];
                prdg_pkg::CFG_BASIS_U:       bu    = val;
                prdg_pkg::CFG_BASIS_V:       bv    = val;
                prdg_pkg::CFG_BASIS_W:       bw    = val;
                prdg_pkg::CFG_GRID_N:        grid  = val[3:0];
                prdg_pkg::CFG_HORIZ_RES:     hres  = val[12:0];
                prdg_pkg::CFG_VERT_RES:      vres  = val[12:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b >>= 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint comp(logic [47:0] pk, int k);
            logic signed [15:0] c;
            c = pk[47-16*k -: 16];
            return longint'(c);
        endfunction

        function void note_pixel(logic [11:0] row, logic [11:0] col);
            longint n, hr, vr, tx, ty, ws, d[3];
            longint unsigned m[3], mx, s, r, qt;
            bit neg[3];
            ray_t ray;
            n = (grid == 0) ? 1 : (grid > 8 ? 8 : grid);
            hr = (hres > 4096) ? 4096 : hres;
            vr = (vres > 4096) ? 4096 : vres;
            ws = longint'(vdist) * 2 * n * 256;
            for (int k = 0; k < n * n; k++) begin
                tx = 2 * n * col - n * hr + 2 * (k % n) + 1;
                ty = 2 * n * row - n * vr + 2 * (k / n) + 1;
                mx = 0;
                for (int i = 0; i < 3; i++) begin
                    d[i] = longint'(psz) * (tx * comp(bu, i) + ty * comp(bv, i))
                           - ws * comp(bw, i);
                    neg[i] = d[i] < 0;
                    m[i] = neg[i] ? -d[i] : d[i];
                    if (m[i] > mx) mx = m[i];
                end
                ray.dx = 0; ray.dy = 0; ray.dz = 0;
                if (mx != 0) begin
                    // bring the largest magnitude into [2^29, 2^30)
                    while (mx >= (64'd1 << 30)) begin
                        mx >>= 1;
                        for (int i = 0; i < 3; i++) m[i] >>= 1;
                    end
                    while (mx < (64'd1 << 29)) begin
                        mx <<= 1;
                        for (int i = 0; i < 3; i++) m[i] <<= 1;
                    end
                    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                    r = root(s);
                    for (int i = 0; i < 3; i++) begin
                        qt = (m[i] * 16384 + r / 2) / r;
                        if (neg[i]) qt = -qt;
                        if (i == 0) ray.dx = qt[15:0];
                        else if (i == 1) ray.dy = qt[15:0];
                        else ray.dz = qt[15:0];
                    end
                end
                ray.prow = 3'(k / n);
                ray.pcol = 3'(k % n);
                ray.last = (k == n * n - 1);
                pending.push_back(ray);
            end
        endfunction

        task check_ray(input logic [55:0] dat, input logic lst);
            ray_t w;
            seen++;
            if (pending.size() == 0) begin
                report("unexpected beat", dat, 0);
                return;
            end
            w = pending.pop_front();
            if (dat[15:0] !== w.dx) report("dir_x", dat[15:0], w.dx);
            if (dat[31:16] !== w.dy) report("dir_y", dat[31:16], w.dy);
            if (dat[47:32] !== w.dz) report("dir_z", dat[47:32], w.dz);
            if (dat[50:48] !== w.prow) report("sub_row", dat[50:48], w.prow);
            if (dat[53:51] !== w.pcol) report("sub_col", dat[53:51], w.pcol);
            if (lst !== w.last) report("last", lst, w.last);
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
    logic s_tready, m_tvalid, m_tlast, cfg_ready;
    logic [23:0] s_tdata = 0;
    logic [55:0] m_tdata;
    logic [2:0]  cfg_index = 0;
    logic [47:0] cfg_data = 0;
    bit calm = 0;
    int quiet = 0;
    int pix_cnt = 0;
    ray_board sb = new();

    always #6 aclk = ~aclk;

    pinhole_ray_direction_generator_top u_top (.*);

    // result side: random stalls except in calm stretches
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_ray(m_tdata, m_tlast);
            ray_cnt++;
        end
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // watchdog on cycles without any accepted beat; a grid-8 pixel is slow
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 40000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // valid stays up after the beat; the next write or the caller drops it
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    // tvalid stays up after the beat unless the next pixel idles first
    task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
        if (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 0;
            do @(posedge aclk); while (!calm && $urandom_range(99) < 23);
        end
        s_tvalid <= 1; s_tdata <= {col, row};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(row, col);
        pix_cnt++;
    endtask

    task automatic drain;
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [47:0] rand_basis();
        logic [63:0] b;
        b = {$urandom(), $urandom()};
        return b[47:0];
    endfunction

    task automatic setup(input logic [15:0] ps, input logic [15:0] vd,
                         input logic [47:0] u, input logic [47:0] v, input logic [47:0] w,
                         input logic [3:0] g, input logic [12:0] h, input logic [12:0] vr);
        drain();
        write_reg(prdg_pkg::CFG_PIXEL_SIZE, 48'(ps));
        write_reg(prdg_pkg::CFG_VIEW_DISTANCE, 48'(vd));
        write_reg(prdg_pkg::CFG_BASIS_U, u);
        write_reg(prdg_pkg::CFG_BASIS_V, v);
        write_reg(prdg_pkg::CFG_BASIS_W, w);
        write_reg(prdg_pkg::CFG_GRID_N, 48'(g));
        write_reg(prdg_pkg::CFG_HORIZ_RES, 48'(h));
        write_reg(prdg_pkg::CFG_VERT_RES, 48'(vr));
        cfg_valid <= 0;
    endtask

    initial begin
        sb.set_reg(prdg_pkg::CFG_PIXEL_SIZE, 48'd256);
        sb.set_reg(prdg_pkg::CFG_VIEW_DISTANCE, 48'd500);
        sb.set_reg(prdg_pkg::CFG_BASIS_U, 48'h4000_0000_0000);
        sb.set_reg(prdg_pkg::CFG_BASIS_V, 48'h0000_4000_0000);
        sb.set_reg(prdg_pkg::CFG_BASIS_W, 48'h0000_0000_4000);
        sb.set_reg(prdg_pkg::CFG_GRID_N, 48'd1);
        sb.set_reg(prdg_pkg::CFG_HORIZ_RES, 48'd640);
        sb.set_reg(prdg_pkg::CFG_VERT_RES, 48'd480);
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset camera, field extremes
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd239, 12'd319);
        send_pixel(12'hAAA, 12'h555);
        // grid 0 acts as one, oversized resolution saturates, zero res
        setup(16'hFFFF, 16'hFFFF, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000,
              48'hFFFF_0001_8000, 4'd0, 13'h1FFF, 13'd0);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
        // zero basis gives a zero vector; grid above max clamps to 8
        setup(16'd0, 16'd0, 48'd0, 48'd0, 48'd0, 4'hF, 13'd4096, 13'd1);
        send_pixel(12'd5, 12'd7);
        setup(16'd1, 16'd1, 48'h4000_0000_0000, 48'h0000_4000_0000,
              48'h0000_0000_4000, 4'd8, 13'd1, 13'd4096);
        send_pixel(12'd0, 12'd0);
        setup(16'h0180, 16'd500, 48'h2D41_2D41_0000, 48'hD2BF_2D41_0000,
              48'h0000_0000_4000, 4'd3, 13'd64, 13'd48);
        for (int i = 0; i < 8; i++)
            send_pixel(12'($urandom_range(47)), 12'($urandom_range(63)));

        // random phases, small grids mostly
        for (int ph = 0; ph < 10; ph++) begin
            setup(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                  (ph % 3 == 0) ? 48'h4000_0000_0000 : rand_basis(),
                  (ph % 3 == 0) ? 48'h0000_4000_0000 : rand_basis(),
                  (ph % 3 == 0) ? 48'h0000_0000_4000 : rand_basis(),
                  (ph == 5) ? 4'd8 : 4'($urandom_range(0, 3)),
                  13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
            calm = (ph == 4);
            for (int i = 0; i < ((ph == 5) ? 6 : 48); i++)
                send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)));
            calm = 0;
        end

        drain();
        $display("covered %0d pixels and %0d rays over 15 camera settings",
                 pix_cnt, ray_cnt);
        if (sb.err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

[pinhole_ray_direction_generator_top.f]
rtl/core/prdg_pkg.sv
rtl/core/prdg_mul.sv
rtl/core/prdg_cmpsub.sv
rtl/core/pinhole_ray_direction_generator_top.sv
rtl/core/prdg_checker.sv
dv/tb_top.sv
